// ===== design/fptw_pkg.sv =====
// Shared types, constants and helpers for the four-level page table walker.
// No dependencies.
package fptw_pkg;

   localparam int VA_W     = 48;
   localparam int FRAME_W  = 40;
   localparam int IDX_W    = 9;
   localparam int OFFSET_W = 12;
   localparam int PA_W     = FRAME_W + OFFSET_W;
   localparam int PAGE_FIELD_W = 6;
   localparam int ENTRIES_PER_TABLE = 512;

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_NOT_PRESENT  = 2'd1;
   localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;

   localparam logic [1:0] LEVEL_TOP  = 2'd3;
   localparam logic [1:0] LEVEL_LEAF = 2'd0;

   typedef struct packed {
      logic                present;
      logic [FRAME_W-1:0]  frame;
   } entry_type;

   // level 3 uses bits 47-39, level 0 bits 20-12
   function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                    input logic [1:0] level);
      logic [IDX_W-1:0] idx;
      case (level)
         2'd3:    idx = va[47:39];
         2'd2:    idx = va[38:30];
         2'd1:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

// ===== design/fptw_store.sv =====
// Table entry store: one write port, one registered read port.
// Depends on fptw_pkg.
module fptw_store
   import fptw_pkg::*;
#(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/four_level_page_table_walk.sv =====
// Four-level page table walker over an on-chip store of table pages.
// A write is answered through the result register; a translation does one store
// read per level, each needing the previous entry's frame.
// Writes: one word per cycle while the result register is free. A translation
// holds off new words until its walk ends. A busy result register parks the word.
// Reset: a clearing pass zeroes all TABLE_PAGES*512 entries (32768 by default) of
// the store; req_ready stays low during it. Depends on fptw_pkg and fptw_store.
module four_level_page_table_walk
   import fptw_pkg::*;
#(
   parameter int TABLE_PAGES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [VA_W-1:0]         req_virtual_address,
   input  logic [PAGE_FIELD_W-1:0] req_table_page,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic                    req_entry_present,
   input  logic [FRAME_W-1:0]      req_entry_frame,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [PA_W-1:0]         rsp_phys_addr,
   input  logic                    csr_wr_en,
   input  logic [PAGE_FIELD_W-1:0] csr_wr_data
);

   localparam int PAGE_W = $clog2(TABLE_PAGES);
   localparam int ADDR_W = PAGE_W + IDX_W;
   localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam logic [FRAME_W-1:0] PAGE_LIMIT = FRAME_W'(TABLE_PAGES);
   localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(DEPTH - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_WALK   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [PAGE_FIELD_W-1:0] root_ff, root_in;
   logic [1:0]              level_ff, level_in;
   logic [VA_W-1:0]         va_ff, va_in;
   logic [1:0]              pend_status_ff, pend_status_in;
   logic [PA_W-1:0]         pend_pa_ff, pend_pa_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [PA_W-1:0]         rsp_pa_ff, rsp_pa_in;

   logic                accept;
   logic                out_free;
   logic                fin_valid;
   logic [1:0]          fin_status;
   logic [PA_W-1:0]     fin_pa;
   logic [FRAME_W-1:0]  root_ext;
   logic [FRAME_W-1:0]  wpage_ext;
   logic [IDX_W-1:0]    top_idx;
   logic [IDX_W-1:0]    next_idx;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   entry_type           mem_wr_data;
   logic [ADDR_W-1:0]   mem_rd_addr;
   entry_type           mem_rd_data;

   fptw_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign root_ext  = FRAME_W'(root_ff);
   assign wpage_ext = FRAME_W'(req_table_page);
   assign top_idx   = level_index(req_virtual_address, LEVEL_TOP);
   assign next_idx  = level_index(va_ff, level_ff - 2'd1);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      root_in        = csr_wr_en ? csr_wr_data : root_ff;
      level_in       = level_ff;
      va_in          = va_ff;
      pend_status_in = pend_status_ff;
      pend_pa_in     = pend_pa_ff;
      fin_valid      = 1'b0;
      fin_status     = STATUS_OK;
      fin_pa         = '0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = {wpage_ext[PAGE_W-1:0], req_entry_index};
      mem_wr_data    = '{present: req_entry_present, frame: req_entry_frame};
      mem_rd_addr    = {root_ext[PAGE_W-1:0], top_idx};

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               va_in    = req_virtual_address;
               level_in = LEVEL_TOP;
               if (req_cmd == CMD_WRITE) begin
                  mem_wr_en = (wpage_ext < PAGE_LIMIT);
                  fin_valid = 1'b1;
               end else if (root_ext >= PAGE_LIMIT) begin
                  fin_valid  = 1'b1;
                  fin_status = STATUS_OUT_OF_RANGE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            mem_rd_addr = {mem_rd_data.frame[PAGE_W-1:0], next_idx};
            level_in    = level_ff - 2'd1;
            if (!mem_rd_data.present) begin
               fin_valid  = 1'b1;
               fin_status = STATUS_NOT_PRESENT;
            end else if (level_ff == LEVEL_LEAF) begin
               fin_valid = 1'b1;
               fin_pa    = {mem_rd_data.frame, va_ff[OFFSET_W-1:0]};
            end else if (mem_rd_data.frame >= PAGE_LIMIT) begin
               fin_valid  = 1'b1;
               fin_status = STATUS_OUT_OF_RANGE;
            end
            if (fin_valid) begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            fin_valid  = 1'b1;
            fin_status = pend_status_ff;
            fin_pa     = pend_pa_ff;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result register busy: park the word and wait
      if (fin_valid && !out_free) begin
         pend_status_in = fin_status;
         pend_pa_in     = fin_pa;
         state_in       = ST_FINISH;
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_pa_in     = rsp_pa_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (fin_valid && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_pa_in     = fin_pa;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff       <= level_in;
      va_ff          <= va_in;
      pend_status_ff <= pend_status_in;
      pend_pa_ff     <= pend_pa_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_pa_ff      <= rsp_pa_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_phys_addr = rsp_pa_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("word accepted during store clear");

   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_WRITE) |=> rsp_valid)
      else $error("write word not answered");

   a_finish_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> rsp_valid_ff)
      else $error("parked result while output register empty");

   a_zero_pa_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_phys_addr == '0))
      else $error("nonzero address with fault status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NOT_PRESENT ||
                     rsp_status == STATUS_OUT_OF_RANGE))
      else $error("undefined status code");

endmodule
